/* rtl/core/ncavg_pkg.sv */
// shared constants and codes for the neighborhood color average block
package ncavg_pkg;

    localparam int MAX_WIDTH   = 64;
    localparam int MAX_HEIGHT  = 64;
    localparam int MAX_RADIUS  = 7;

    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    localparam int CHAN_W      = 8;
    localparam int NUM_CHAN    = 3;
    localparam int PIX_W       = NUM_CHAN * CHAN_W;
    localparam int COORD_W     = 8;
    localparam int RADIUS_W    = 3;
    localparam int FRAME_W     = 7;
    localparam int MEAN_W      = 16;
    localparam int COUNT_W     = 8;

    localparam int MAX_SAMPLES = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
    localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W       = CHAN_W + CNT_W;
    localparam int FRAC_W      = 8;
    localparam int DVD_W       = SUM_W + FRAC_W;
    localparam int STEP_W      = $clog2(DVD_W);
    localparam int OFS_W       = $clog2(MAX_RADIUS + 1) + 1;
    localparam int POS_W       = COORD_W + 2;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = FRAME_W;

    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [FRAME_W-1:0] FRAME_RESET = 7'd64;

endpackage

/* rtl/core/neighborhood_color_average.sv */
// frame store with clipped box-filter mean query
//
// input channel in_valid/in_ready carries one item per transfer: operation
// selects a pixel write or a neighborhood query. a write stores red_in,
// green_in, blue_in at (x_coord, y_coord) in a 4096 x 24 synchronous ram;
// writes outside the frame are dropped. a query scans the
// window of side 2r+1 around (x_coord, y_coord), one ram read per cycle, then
// runs a radix-2 restoring divider on the three channel sums; the window has
// n = (2r+1)^2 positions, and the divider is skipped when no sample is
// inside. the next item can be taken once the result appears; no new item
// is taken while a query is in progress.
// results leave on out_valid/out_ready from an output register; the core
// goes on with the next item while a result waits, and only stalls at the
// end of a query whose result would overwrite one not yet taken.
// cfg_en writes frame_width (index 0) or frame_height (index 1) from cfg_data.
// reset sets both sizes to 64 and empties the output register; the ram is
// not cleared, so pixels must be written before they are queried.
module neighborhood_color_average
    import ncavg_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,

    input  logic                     cfg_en,
    input  logic [CFG_INDEX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data,

    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     operation,
    input  logic signed [COORD_W-1:0] x_coord,
    input  logic signed [COORD_W-1:0] y_coord,
    input  logic [CHAN_W-1:0]        red_in,
    input  logic [CHAN_W-1:0]        green_in,
    input  logic [CHAN_W-1:0]        blue_in,
    input  logic [RADIUS_W-1:0]      window_radius,

    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [MEAN_W-1:0]        mean_red,
    output logic [MEAN_W-1:0]        mean_green,
    output logic [MEAN_W-1:0]        mean_blue,
    output logic [COUNT_W-1:0]       sample_count
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_LOAD,
        ST_DIV,
        ST_FINISH
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;
    logic   samp_valid_reg;

    logic [FRAME_W-1:0] frame_width_reg;
    logic [FRAME_W-1:0] frame_height_reg;
    logic [FRAME_W-1:0] eff_w;
    logic [FRAME_W-1:0] eff_h;

    logic [PIX_W-1:0] mem [STORE_DEPTH];
    logic [PIX_W-1:0] rd_data_reg;

    logic signed [COORD_W-1:0] cx_reg;
    logic signed [COORD_W-1:0] cy_reg;
    logic signed [OFS_W-1:0]   rad_reg;
    logic signed [OFS_W-1:0]   dx_reg;
    logic signed [OFS_W-1:0]   dy_reg;
    logic [SUM_W-1:0]          sum_reg [NUM_CHAN];
    logic [CNT_W-1:0]          count_reg;
    logic [DVD_W-1:0]          dq_reg  [NUM_CHAN];
    logic [CNT_W-1:0]          rem_reg [NUM_CHAN];
    logic [STEP_W-1:0]         step_reg;

    logic [MEAN_W-1:0]  mean_reg [NUM_CHAN];
    logic [COUNT_W-1:0] sample_count_reg;

    logic in_xfer;
    logic out_xfer;
    logic wr_inside;
    logic mem_we;
    logic [ADDR_W-1:0] wr_addr;
    logic [PIX_W-1:0]  wr_data;

    logic signed [OFS_W-1:0] rad_sat;
    logic signed [POS_W-1:0] sx;
    logic signed [POS_W-1:0] sy;
    logic                    rd_inside;
    logic [ADDR_W-1:0]       rd_addr;
    logic                    scan_last;
    logic                    finish_go;

    logic [CNT_W:0]    trial   [NUM_CHAN];
    logic              qbit    [NUM_CHAN];
    logic [CNT_W-1:0]  rem_new [NUM_CHAN];

    assign in_ready     = (state_reg == ST_IDLE);
    assign in_xfer      = in_valid && in_ready;
    assign out_xfer     = out_valid_reg && out_ready;
    assign out_valid    = out_valid_reg;
    assign mean_red     = mean_reg[0];
    assign mean_green   = mean_reg[1];
    assign mean_blue    = mean_reg[2];
    assign sample_count = sample_count_reg;

    always_comb
    begin
        eff_w = (int'(frame_width_reg) > MAX_WIDTH) ? FRAME_W'(MAX_WIDTH) : frame_width_reg;
        eff_h = (int'(frame_height_reg) > MAX_HEIGHT) ? FRAME_W'(MAX_HEIGHT)
                                                      : frame_height_reg;

        // pixel write path
        wr_inside = !x_coord[COORD_W-1] && !y_coord[COORD_W-1]
                    && (int'(x_coord[COORD_W-2:0]) < int'(eff_w))
                    && (int'(y_coord[COORD_W-2:0]) < int'(eff_h));
        wr_addr   = ADDR_W'(int'(y_coord[COORD_W-2:0]) * MAX_WIDTH
                            + int'(x_coord[COORD_W-2:0]));
        wr_data   = {red_in, green_in, blue_in};
        mem_we    = in_xfer && (operation == OP_WRITE) && wr_inside;

        rad_sat = (int'(window_radius) > MAX_RADIUS) ? OFS_W'(MAX_RADIUS)
                                                     : OFS_W'(window_radius);

        // window sample position
        sx = $signed({{(POS_W-COORD_W){cx_reg[COORD_W-1]}}, cx_reg})
             + $signed({{(POS_W-OFS_W){dx_reg[OFS_W-1]}}, dx_reg});
        sy = $signed({{(POS_W-COORD_W){cy_reg[COORD_W-1]}}, cy_reg})
             + $signed({{(POS_W-OFS_W){dy_reg[OFS_W-1]}}, dy_reg});
        rd_inside = !sx[POS_W-1] && !sy[POS_W-1]
                    && (int'(sx[POS_W-2:0]) < int'(eff_w))
                    && (int'(sy[POS_W-2:0]) < int'(eff_h));
        rd_addr   = ADDR_W'(int'(sy[POS_W-2:0]) * MAX_WIDTH + int'(sx[POS_W-2:0]));
        scan_last = (dx_reg == rad_reg) && (dy_reg == rad_reg);

        finish_go = !out_valid_reg || out_ready;

        // restoring divider step, one per lane
        for (int i = 0; i < NUM_CHAN; i++)
        begin
            trial[i] = {rem_reg[i], dq_reg[i][DVD_W-1]};
            qbit[i]  = (trial[i] >= {1'b0, count_reg});
            if (qbit[i])
            begin
                rem_new[i] = CNT_W'(trial[i] - {1'b0, count_reg});
            end
            else
            begin
                rem_new[i] = trial[i][CNT_W-1:0];
            end
        end
    end

    // pixel ram
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // control state and registered output flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            out_valid_reg    <= 1'b0;
            samp_valid_reg   <= 1'b0;
            frame_width_reg  <= FRAME_RESET;
            frame_height_reg <= FRAME_RESET;
        end
        else
        begin
            if (cfg_en)
            begin
                unique case (cfg_index)
                    CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                    CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                    default:          ;
                endcase
            end

            samp_valid_reg <= (state_reg == ST_SCAN) && rd_inside;

            if (out_xfer && !((state_reg == ST_FINISH) && finish_go))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_xfer && (operation == OP_QUERY))
                    begin
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    if (scan_last)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    state_reg <= ST_LOAD;
                end
                ST_LOAD:
                begin
                    state_reg <= (count_reg == '0) ? ST_FINISH : ST_DIV;
                end
                ST_DIV:
                begin
                    if (step_reg == STEP_W'(DVD_W - 1))
                    begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH:
                begin
                    if (finish_go)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE)
        begin
            cx_reg    <= x_coord;
            cy_reg    <= y_coord;
            rad_reg   <= rad_sat;
            dx_reg    <= -rad_sat;
            dy_reg    <= -rad_sat;
            count_reg <= '0;
            for (int i = 0; i < NUM_CHAN; i++)
            begin
                sum_reg[i] <= '0;
            end
        end
        else
        begin
            if (state_reg == ST_SCAN)
            begin
                if (dx_reg == rad_reg)
                begin
                    dx_reg <= -rad_reg;
                    dy_reg <= dy_reg + OFS_W'(1);
                end
                else
                begin
                    dx_reg <= dx_reg + OFS_W'(1);
                end
            end

            if (samp_valid_reg)
            begin
                count_reg <= count_reg + CNT_W'(1);
                for (int i = 0; i < NUM_CHAN; i++)
                begin
                    sum_reg[i] <= sum_reg[i]
                                  + SUM_W'(rd_data_reg[PIX_W-1-CHAN_W*i -: CHAN_W]);
                end
            end
        end

        if (state_reg == ST_LOAD)
        begin
            step_reg <= '0;
            for (int i = 0; i < NUM_CHAN; i++)
            begin
                rem_reg[i] <= '0;
                dq_reg[i]  <= (count_reg == '0) ? '0 : {sum_reg[i], FRAC_W'(0)};
            end
        end
        else if (state_reg == ST_DIV)
        begin
            step_reg <= step_reg + STEP_W'(1);
            for (int i = 0; i < NUM_CHAN; i++)
            begin
                rem_reg[i] <= rem_new[i];
                dq_reg[i]  <= {dq_reg[i][DVD_W-2:0], qbit[i]};
            end
        end

        if ((state_reg == ST_FINISH) && finish_go)
        begin
            sample_count_reg <= COUNT_W'(count_reg);
            for (int i = 0; i < NUM_CHAN; i++)
            begin
                mean_reg[i] <= dq_reg[i][MEAN_W-1:0];
            end
        end
    end

endmodule

/* bench/window_mean_checker.sv */
// checker for neighborhood_color_average: frame model, window mean prediction, compare
module window_mean_checker
    import ncavg_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_en,
    input  logic [CFG_INDEX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data,
    input  logic                      in_valid,
    input  logic                      in_ready,
    input  logic                      operation,
    input  logic signed [COORD_W-1:0] x_coord,
    input  logic signed [COORD_W-1:0] y_coord,
    input  logic [CHAN_W-1:0]         red_in,
    input  logic [CHAN_W-1:0]         green_in,
    input  logic [CHAN_W-1:0]         blue_in,
    input  logic [RADIUS_W-1:0]       window_radius,
    input  logic                      out_valid,
    input  logic                      out_ready,
    input  logic [MEAN_W-1:0]         mean_red,
    input  logic [MEAN_W-1:0]         mean_green,
    input  logic [MEAN_W-1:0]         mean_blue,
    input  logic [COUNT_W-1:0]        sample_count,
    output int                        fail_count,
    output int                        outstanding
);

    typedef struct packed {
        logic [MEAN_W-1:0]  red;
        logic [MEAN_W-1:0]  green;
        logic [MEAN_W-1:0]  blue;
        logic [COUNT_W-1:0] count;
    } window_mean_t;

    logic [PIX_W-1:0] frame_store [STORE_DEPTH];
    int               width_reg = FRAME_RESET;
    int               height_reg = FRAME_RESET;
    window_mean_t     mean_q [$];
    int               errors = 0;

    function automatic bit on_frame(int col, int row);
        int cols;
        int rows;
        cols = (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
        rows = (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
        return (col >= 0) && (row >= 0) && (col < cols) && (row < rows);
    endfunction

    function automatic window_mean_t window_mean(int cx, int cy, int radius);
        window_mean_t     res;
        int unsigned      red_sum;
        int unsigned      green_sum;
        int unsigned      blue_sum;
        int unsigned      hits;
        int               span;
        logic [PIX_W-1:0] pix;
        red_sum = 0;
        green_sum = 0;
        blue_sum = 0;
        hits = 0;
        span = (radius > MAX_RADIUS) ? MAX_RADIUS : radius;
        for (int dy = -span; dy <= span; dy++)
        begin
            for (int dx = -span; dx <= span; dx++)
            begin
                if (on_frame(cx + dx, cy + dy))
                begin
                    pix = frame_store[ADDR_W'((cy + dy) * MAX_WIDTH + cx + dx)];
                    red_sum += pix[2*CHAN_W +: CHAN_W];
                    green_sum += pix[CHAN_W +: CHAN_W];
                    blue_sum += pix[0 +: CHAN_W];
                    hits++;
                end
            end
        end
        res = '0;
        if (hits != 0)
        begin
            res.red = MEAN_W'((red_sum << FRAC_W) / hits);
            res.green = MEAN_W'((green_sum << FRAC_W) / hits);
            res.blue = MEAN_W'((blue_sum << FRAC_W) / hits);
            res.count = COUNT_W'(hits);
        end
        return res;
    endfunction

    task automatic check_field(string field, int want, int got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        window_mean_t want;
        if (!rst_n)
        begin
            width_reg = FRAME_RESET;
            height_reg = FRAME_RESET;
            mean_q.delete();
            foreach (frame_store[i])
                frame_store[i] = '0;
        end
        else
        begin
            if (cfg_en)
            begin
                if (cfg_index == CFG_FRAME_WIDTH)
                    width_reg = int'(cfg_data);
                else if (cfg_index == CFG_FRAME_HEIGHT)
                    height_reg = int'(cfg_data);
            end
            if (in_valid && in_ready)
            begin
                if (operation == OP_WRITE)
                begin
                    if (on_frame(int'(x_coord), int'(y_coord)))
                        frame_store[ADDR_W'(int'(y_coord) * MAX_WIDTH + int'(x_coord))] =
                            {red_in, green_in, blue_in};
                end
                else
                begin
                    mean_q.push_back(window_mean(int'(x_coord), int'(y_coord),
                                                 int'(window_radius)));
                end
            end
            // result transfer
            if (out_valid && out_ready)
            begin
                if (mean_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result, expected none, actual %0d %0d %0d count %0d",
                             $time, mean_red, mean_green, mean_blue, sample_count);
                end
                else
                begin
                    want = mean_q.pop_front();
                    check_field("mean_red", int'(want.red), int'(mean_red));
                    check_field("mean_green", int'(want.green), int'(mean_green));
                    check_field("mean_blue", int'(want.blue), int'(mean_blue));
                    check_field("sample_count", int'(want.count), int'(sample_count));
                end
            end
        end
        fail_count <= errors;
        outstanding <= mean_q.size();
    end

endmodule

/* bench/neighborhood_color_average_test.sv */
// testbench top for neighborhood_color_average: drives pixel writes, window queries and frame sizes
module neighborhood_color_average_test;
    import ncavg_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 2'd3;
    localparam int SETTLE_CYCLES   = 300;
    localparam int QUIET_LIMIT     = 20000;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 66;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_en = 1'b0;
    logic [CFG_INDEX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]     cfg_data = '0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic                      operation = OP_WRITE;
    logic signed [COORD_W-1:0] x_coord = '0;
    logic signed [COORD_W-1:0] y_coord = '0;
    logic [CHAN_W-1:0]         red_in = '0;
    logic [CHAN_W-1:0]         green_in = '0;
    logic [CHAN_W-1:0]         blue_in = '0;
    logic [RADIUS_W-1:0]       window_radius = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic [MEAN_W-1:0]         mean_red;
    logic [MEAN_W-1:0]         mean_green;
    logic [MEAN_W-1:0]         mean_blue;
    logic [COUNT_W-1:0]        sample_count;
    int                        fail_count;
    int                        outstanding;

    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int cols_used = MAX_WIDTH;
    int rows_used = MAX_HEIGHT;
    int quiet_cycles = 0;
    int sent_items = 0;
    bit painted [MAX_HEIGHT][MAX_WIDTH];

    neighborhood_color_average dut (.*);

    window_mean_checker mean_check (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= receiver_stall_pct);

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("neighborhood_color_average regression: fail");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic bit in_frame(int col, int row);
        return (col >= 0) && (row >= 0) && (col < cols_used) && (row < rows_used);
    endfunction

    // in-frame pixels of a window not yet written
    function automatic int unpainted(int col, int row, int radius);
        int needed;
        needed = 0;
        for (int dy = -radius; dy <= radius; dy++)
        begin
            for (int dx = -radius; dx <= radius; dx++)
            begin
                if (in_frame(col + dx, row + dy) && !painted[row + dy][col + dx])
                    needed++;
            end
        end
        return needed;
    endfunction

    task automatic send_item(logic op, int col, int row, int red, int green, int blue,
                             int radius);
        @(negedge clk);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        operation <= op;
        x_coord <= COORD_W'(col);
        y_coord <= COORD_W'(row);
        red_in <= CHAN_W'(red);
        green_in <= CHAN_W'(green);
        blue_in <= CHAN_W'(blue);
        window_radius <= RADIUS_W'(radius);
        do
            @(posedge clk);
        while (!in_ready);
        sent_items++;
    endtask

    task automatic put_pixel(int col, int row, int red, int green, int blue);
        send_item(OP_WRITE, col, row, red, green, blue, $urandom_range(MAX_RADIUS));
        if (in_frame(col, row))
            painted[row][col] = 1'b1;
    endtask

    // every in-frame pixel of the window gets written before the query
    task automatic ask_window(int col, int row, int radius);
        for (int dy = -radius; dy <= radius; dy++)
        begin
            for (int dx = -radius; dx <= radius; dx++)
            begin
                if (in_frame(col + dx, row + dy) && !painted[row + dy][col + dx])
                    put_pixel(col + dx, row + dy, $urandom_range(255), $urandom_range(255),
                              $urandom_range(255));
            end
        end
        send_item(OP_QUERY, col, row, $urandom_range(255), $urandom_range(255),
                  $urandom_range(255), radius);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic settle();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(logic [CFG_INDEX_W-1:0] idx, int val);
        logic [CFG_DATA_W-1:0] field;
        field = CFG_DATA_W'(val);
        @(negedge clk);
        cfg_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= field;
        @(negedge clk);
        cfg_en <= 1'b0;
        if (idx == CFG_FRAME_WIDTH)
            cols_used = (int'(field) > MAX_WIDTH) ? MAX_WIDTH : int'(field);
        else if (idx == CFG_FRAME_HEIGHT)
            rows_used = (int'(field) > MAX_HEIGHT) ? MAX_HEIGHT : int'(field);
    endtask

    task automatic set_frame(int cols, int rows);
        settle();
        write_register(CFG_FRAME_WIDTH, cols);
        write_register(CFG_FRAME_HEIGHT, rows);
    endtask

    // room is the number of items still left in the phase
    task automatic random_item(int room);
        int col;
        int row;
        int radius;
        if ($urandom_range(99) < 35)
        begin
            if (cols_used > 0 && rows_used > 0 && $urandom_range(3) != 0)
            begin
                col = $urandom_range(cols_used - 1);
                row = $urandom_range(rows_used - 1);
            end
            else
            begin
                col = $urandom_range(191) - 64;
                row = $urandom_range(191) - 64;
            end
            put_pixel(col, row, $urandom_range(255), $urandom_range(255), $urandom_range(255));
        end
        else
        begin
            if ($urandom_range(99) < 85)
            begin
                col = $urandom_range(cols_used + 15) - 8;
                row = $urandom_range(rows_used + 15) - 8;
            end
            else
            begin
                col = $urandom_range(191) - 64;
                row = $urandom_range(191) - 64;
            end
            radius = $urandom_range(MAX_RADIUS);
            // shrink the window while its pixel fill would not fit the phase
            while (radius > 0 && unpainted(col, row, radius) >= room)
                radius--;
            ask_window(col, row, radius);
        end
    endtask

    initial
    begin
        int phase_start;
        bit held;
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // corners, ignored writes, clipped and empty windows at reset size
        put_pixel(MAX_WIDTH - 1, MAX_HEIGHT - 1, 255, 255, 255);
        put_pixel(0, 0, 0, 0, 0);
        put_pixel(MAX_WIDTH, 10, 17, 34, 51);
        put_pixel(10, MAX_HEIGHT, 17, 34, 51);
        put_pixel(-64, -64, 255, 255, 255);
        put_pixel(127, 127, 255, 255, 255);
        ask_window(MAX_WIDTH - 1, MAX_HEIGHT - 1, 0);
        ask_window(0, 0, 0);
        ask_window(70, 70, MAX_RADIUS);
        ask_window(-7, -7, MAX_RADIUS);
        ask_window(-64, -64, MAX_RADIUS);
        ask_window(127, 127, 0);

        // single pixel frame
        set_frame(1, 1);
        put_pixel(0, 0, 128, 64, 1);
        ask_window(0, 0, MAX_RADIUS);
        ask_window(1, 0, 0);

        // zero width: nothing is inside
        set_frame(0, 1);
        put_pixel(0, 0, 9, 9, 9);
        ask_window(0, 0, MAX_RADIUS);

        // oversized sizes saturate, spare indexes do nothing
        set_frame(127, 127);
        write_register(CFG_SPARE_LO, 0);
        write_register(CFG_SPARE_HI, 1);
        ask_window(70, 70, MAX_RADIUS);
        ask_window(-7, -7, MAX_RADIUS);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: set_frame(64, 64);
                1: set_frame(1, 64);
                2: set_frame(64, 1);
                3: set_frame(0, 30);
                4: set_frame(127, 5);
                7: set_frame($urandom_range(1, 64), $urandom_range(1, 64));
                default: set_frame($urandom_range(1, 24), $urandom_range(1, 24));
            endcase
            case (phase % 4)
                0:
                begin
                    sender_idle_pct = 0;
                    receiver_stall_pct = 0;
                end
                1:
                begin
                    sender_idle_pct = 61;
                    receiver_stall_pct = 0;
                end
                2:
                begin
                    sender_idle_pct = 0;
                    receiver_stall_pct = 61;
                end
                default:
                begin
                    sender_idle_pct = 13;
                    receiver_stall_pct = 13;
                end
            endcase
            phase_start = sent_items;
            held = 1'b0;
            while (sent_items - phase_start < ITEMS_PER_PHASE)
            begin
                // hold the sender until every result is back
                if (!held && sent_items - phase_start >= ITEMS_PER_PHASE / 2)
                begin
                    wait_drained();
                    held = 1'b1;
                end
                random_item(ITEMS_PER_PHASE - (sent_items - phase_start));
            end
        end

        settle();
        if (fail_count == 0)
            $display("neighborhood_color_average regression: pass");
        else
            $display("neighborhood_color_average regression: fail");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/ncavg_pkg.sv
rtl/core/neighborhood_color_average.sv
bench/window_mean_checker.sv
bench/neighborhood_color_average_test.sv
